// ----- hdl/upsdf_pkg.sv -----
`timescale 1ns / 1ps

package upsdf_pkg;

	localparam int PACKET_BYTES = 25;
	localparam int CNT_W = $clog2(PACKET_BYTES);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PACKET_BYTES - 1);
	localparam logic [CNT_W-1:0] SUM_IDX = CNT_W'(PACKET_BYTES - 2);

	localparam logic [7:0] DELIM = 8'hFE;
	localparam logic [3:0] TYPE_A = 4'hA;
	localparam logic [3:0] TYPE_B = 4'hB;
	localparam logic [10:0] YEAR_BASE = 11'd1998;
	localparam logic [7:0] XFER_LOW_220 = 8'd150;
	localparam logic [7:0] XFER_LOW_110 = 8'd75;
	localparam logic [1:0] SCHED_FROM_PKT = 2'd3;

	// configuration register index (byte address / 4)
	localparam logic REG_SCHED_MODE = 1'b0;
	localparam logic REG_HOST_WDAY = 1'b1;

	typedef enum logic [1:0] {
		PKT_OK      = 2'd0,
		PKT_CKSUM   = 2'd1,
		PKT_NODELIM = 2'd2,
		PKT_BADTYPE = 2'd3
	} pkt_status_t;

	// fields of one framed packet that the decoder needs
	typedef struct packed {
		pkt_status_t status;
		logic [7:0]  model;
		logic [7:0]  temp;
		logic [23:0] hms;
		logic [15:0] on_time;
		logic [15:0] shut_time;
		logic [6:0]  days_raw;
		logic [7:0]  day_byte;
		logic [7:0]  date_byte;
		logic [7:0]  flag_byte;
	} frame_rec_t;

	typedef struct packed {
		logic       push;
		frame_rec_t rec;
	} q_wr_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} q_rd_t;

endpackage

// ----- hdl/upsdf_byte_if.sv -----
`timescale 1ns / 1ps

interface upsdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/upsdf_result_if.sv -----
`timescale 1ns / 1ps

interface upsdf_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        packet_status;
	logic [7:0]        model_code;
	logic [10:0]       clock_year;
	logic [3:0]        clock_month;
	logic [4:0]        clock_day;
	logic [23:0]       clock_hms;
	logic [7:0]        state_flags;
	logic signed [7:0] temperature_c;
	logic [6:0]        shutdown_days;
	logic [15:0]       power_on_time;
	logic [15:0]       power_off_time;
	logic [7:0]        transfer_low_volts;

	modport source (
		output valid, output packet_status, output model_code, output clock_year,
		output clock_month, output clock_day, output clock_hms, output state_flags,
		output temperature_c, output shutdown_days, output power_on_time,
		output power_off_time, output transfer_low_volts, input ready
	);
	modport sink (
		input valid, input packet_status, input model_code, input clock_year,
		input clock_month, input clock_day, input clock_hms, input state_flags,
		input temperature_c, input shutdown_days, input power_on_time,
		input power_off_time, input transfer_low_volts, output ready
	);
endinterface

// ----- hdl/upsdf_front.sv -----
`timescale 1ns / 1ps

module upsdf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	upsdf_byte_if.sink            rx,
	input  logic                  q_ready,
	output upsdf_pkg::q_wr_t      q_wr
);

	logic                              hunting_q;
	logic [upsdf_pkg::CNT_W-1:0]       count_q;
	logic [7:0]                        acc_q;
	logic [7:0]                        frame_q [upsdf_pkg::PACKET_BYTES-1];
	logic                              last;
	logic                              take;
	upsdf_pkg::pkt_status_t            status;
	logic [3:0]                        ptype;

	assign last = !hunting_q && (count_q == upsdf_pkg::LAST_IDX);
	// the closing beat needs room in the queue; all other beats flow freely
	assign rx.ready = !last || q_ready;
	assign take = rx.valid && rx.ready;

	assign ptype = frame_q[0][7:4];

	always_comb begin
		if (rx.rx_byte != upsdf_pkg::DELIM) begin
			status = upsdf_pkg::PKT_NODELIM;
		end else if (acc_q != frame_q[upsdf_pkg::PACKET_BYTES-2]) begin
			status = upsdf_pkg::PKT_CKSUM;
		end else if (ptype != upsdf_pkg::TYPE_A && ptype != upsdf_pkg::TYPE_B) begin
			status = upsdf_pkg::PKT_BADTYPE;
		end else begin
			status = upsdf_pkg::PKT_OK;
		end
	end

	always_comb begin
		q_wr.push = take && last;
		q_wr.rec.status = status;
		q_wr.rec.model = frame_q[0];
		q_wr.rec.temp = frame_q[4];
		q_wr.rec.hms = {frame_q[11], frame_q[10], frame_q[9]};
		q_wr.rec.on_time = {frame_q[13], frame_q[14]};
		q_wr.rec.shut_time = {frame_q[15], frame_q[16]};
		q_wr.rec.days_raw = frame_q[17][6:0];
		q_wr.rec.day_byte = frame_q[18];
		q_wr.rec.date_byte = frame_q[19];
		q_wr.rec.flag_byte = frame_q[20];
	end

	always_ff @(posedge clk) begin
		if (take && !hunting_q && !last) begin
			frame_q[count_q] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			count_q <= '0;
			acc_q <= '0;
		end else if (take) begin
			if (hunting_q) begin
				if (rx.rx_byte == upsdf_pkg::DELIM) begin
					hunting_q <= 1'b0;
					count_q <= '0;
					acc_q <= '0;
				end
			end else if (last) begin
				count_q <= '0;
				acc_q <= '0;
				if (rx.rx_byte != upsdf_pkg::DELIM) begin
					hunting_q <= 1'b1;
				end
			end else begin
				count_q <= count_q + 1'b1;
				if (count_q < upsdf_pkg::SUM_IDX) begin
					acc_q <= acc_q + rx.rx_byte;
				end
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= upsdf_pkg::LAST_IDX)
		else $error("frame byte counter out of range");

	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push && q_wr.rec.status == upsdf_pkg::PKT_NODELIM |=> hunting_q)
		else $error("missing delimiter did not restart the hunt");

endmodule

// ----- hdl/upsdf_queue.sv -----
`timescale 1ns / 1ps

module upsdf_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  upsdf_pkg::q_wr_t wr,
	output logic             wr_ready,
	output upsdf_pkg::q_rd_t rd,
	input  logic             pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	upsdf_pkg::frame_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  do_pop;

	assign wr_ready = (count_q != CNT_FULL);
	assign rd.valid = (count_q != '0);
	assign rd.rec = mem_q[rd_ptr_q];
	assign do_pop = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (wr.push && wr_ready) begin
			mem_q[wr_ptr_q] <= wr.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr.push && wr_ready) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr.push && wr_ready, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> wr_ready)
		else $error("frame pushed into a full queue");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue fill count beyond depth");

endmodule

// ----- hdl/upsdf_back.sv -----
`timescale 1ns / 1ps

module upsdf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  upsdf_pkg::q_rd_t  rd,
	output logic              pop,
	input  logic [1:0]        schedule_mode,
	input  logic [2:0]        host_weekday,
	upsdf_result_if.source    res
);

	function automatic logic [6:0] rot_days(input logic [6:0] v, input logic [2:0] wd);
		logic [2:0]  r;
		logic [13:0] ext;
		case (wd)
			3'd6:    r = 3'd0;
			3'd7:    r = 3'd1;
			default: r = wd + 3'd1;
		endcase
		ext = {v, v} >> (3'd7 - r);
		return ext[6:0];
	endfunction

	logic        out_valid_q;
	logic        latched_q;
	logic [7:0]  model_q;
	logic        sticky_q;
	logic [6:0]  days_q;
	logic [15:0] on_q;
	logic [15:0] off_q;

	logic        ok;
	logic        sched;
	logic [7:0]  f;
	logic        onbatt;
	logic [7:0]  model_n;
	logic        sticky_n;
	logic [6:0]  days_n;
	logic [15:0] on_n;
	logic [15:0] off_n;

	logic [1:0]  status_q;
	logic [10:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [23:0] hms_q;
	logic [7:0]  flags_q;
	logic [7:0]  temp_q;
	logic [6:0]  sdays_q;
	logic [15:0] pon_q;
	logic [15:0] poff_q;
	logic [7:0]  xfer_q;
	logic [7:0]  mcode_q;

	assign pop = rd.valid && (!out_valid_q || res.ready);

	assign ok = (rd.rec.status == upsdf_pkg::PKT_OK);
	assign sched = ok && (schedule_mode == upsdf_pkg::SCHED_FROM_PKT);
	assign f = rd.rec.flag_byte;
	assign onbatt = f[5];

	assign model_n = (ok && !latched_q) ? rd.rec.model : model_q;
	assign sticky_n = sticky_q || (ok && f[0]);
	assign days_n = sched ? rot_days(rd.rec.days_raw, host_weekday) : days_q;
	assign on_n = sched ? rd.rec.on_time : on_q;
	assign off_n = sched ? rd.rec.shut_time : off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			latched_q <= 1'b0;
			model_q <= '0;
			sticky_q <= 1'b0;
			days_q <= '0;
			on_q <= '0;
			off_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				latched_q <= latched_q || ok;
				model_q <= model_n;
				sticky_q <= sticky_n;
				days_q <= days_n;
				on_q <= on_n;
				off_q <= off_n;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// dropped frames report status and model only
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= rd.rec.status;
			mcode_q <= model_n;
			if (ok) begin
				year_q <= 11'(rd.rec.date_byte[3:0]) + upsdf_pkg::YEAR_BASE;
				month_q <= rd.rec.date_byte[7:4];
				day_q <= rd.rec.day_byte[4:0];
				hms_q <= rd.rec.hms;
				flags_q <= {sticky_n, f[6], f[1] && !onbatt, f[7], onbatt, f[4], f[3], f[2]};
				temp_q <= rd.rec.temp;
				sdays_q <= days_n;
				pon_q <= on_n;
				poff_q <= off_n;
				xfer_q <= f[6] ? upsdf_pkg::XFER_LOW_220 : upsdf_pkg::XFER_LOW_110;
			end else begin
				year_q <= '0;
				month_q <= '0;
				day_q <= '0;
				hms_q <= '0;
				flags_q <= '0;
				temp_q <= '0;
				sdays_q <= '0;
				pon_q <= '0;
				poff_q <= '0;
				xfer_q <= '0;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.packet_status = status_q;
	assign res.model_code = mcode_q;
	assign res.clock_year = year_q;
	assign res.clock_month = month_q;
	assign res.clock_day = day_q;
	assign res.clock_hms = hms_q;
	assign res.state_flags = flags_q;
	assign res.temperature_c = signed'(temp_q);
	assign res.shutdown_days = sdays_q;
	assign res.power_on_time = pon_q;
	assign res.power_off_time = poff_q;
	assign res.transfer_low_volts = xfer_q;

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q |=> sticky_q)
		else $error("output-220V flag dropped");

	a_model_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q |=> latched_q && model_q == $past(model_q))
		else $error("latched model code changed");

endmodule

// ----- hdl/ups_status_packet_deframer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Beat
// rx        in   rx_byte[7:0]                    one received serial byte
// res       out  packet_status .. transfer_low   one result per framed packet
// apb       in   paddr[2:0], pwdata/prdata[31:0] schedule_mode (0x0), host_weekday (0x4)
//
// One byte is taken every cycle but when rx stalls; results are queued, then registered.
// The front stalls rx only on a closing byte when the frame queue is full.
// Hunting bytes and mid-frame bytes produce no result.
// Reset: hunt for 0xFE, model not latched, schedule and flags cleared, registers 0.
// A stalled res holds its result; the queue keeps the front running meanwhile.

module ups_status_packet_deframer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	upsdf_byte_if.sink     rx,
	upsdf_result_if.source res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [1:0]       sched_mode_q;
	logic [2:0]       weekday_q;
	upsdf_pkg::q_wr_t q_wr;
	upsdf_pkg::q_rd_t q_rd;
	logic             q_ready;
	logic             pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_mode_q <= '0;
			weekday_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				upsdf_pkg::REG_SCHED_MODE: sched_mode_q <= pwdata[1:0];
				upsdf_pkg::REG_HOST_WDAY:  weekday_q <= pwdata[2:0];
				default:                   sched_mode_q <= sched_mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			upsdf_pkg::REG_SCHED_MODE: prdata = {30'b0, sched_mode_q};
			upsdf_pkg::REG_HOST_WDAY:  prdata = {29'b0, weekday_q};
			default:                   prdata = '0;
		endcase
	end

	upsdf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.q_ready (q_ready),
		.q_wr    (q_wr)
	);

	upsdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_ready (q_ready),
		.rd       (q_rd),
		.pop      (pop)
	);

	upsdf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd            (q_rd),
		.pop           (pop),
		.schedule_mode (sched_mode_q),
		.host_weekday  (weekday_q),
		.res           (res)
	);

endmodule
